FILE: hdl/assert_macros.svh
// Concurrent assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

FILE: hdl/lcab_pkg.sv
// Types, constants and command codes for the binary lifting ancestor engine
package lcab_pkg;

    // Width of node numbers and depths on the channels and in the stores
    localparam int NODE_W     = 10;
    // Width of the level field in a datapath command (up to 32 levels)
    localparam int LVL_W      = 5;
    localparam int DEF_NODES  = 1024;
    localparam int DEF_LEVELS = 10;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD_RD,
        OP_ADD_DEP,
        OP_ADD_LVL,
        OP_QDA,
        OP_QDB,
        OP_QDIFF,
        OP_LIFT,
        OP_JOINT,
        OP_FINRD,
        OP_OUT_ADD,
        OP_OUT_A,
        OP_OUT_J
    } dp_op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_DEP,
        S_ADD_LVL,
        S_Q_DB,
        S_Q_DIFF,
        S_LIFT,
        S_CHECK,
        S_JOINT,
        S_FINAL,
        S_OUT_ADD,
        S_OUT_A,
        S_OUT_J
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t             op;
        logic [LVL_W-1:0]   level;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_add;
        logic is_query;
        logic same;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/lcab_ifs.sv
// Valid/ready channel interfaces for request and result beats
interface lcab_in_if import lcab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other;

    modport source (output valid, output func, output node, output other, input ready);
    modport sink   (input valid, input func, input node, input other, output ready);
endinterface

interface lcab_out_if import lcab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] ancestor;
    logic              status;

    modport source (output valid, output ancestor, output status, input ready);
    modport sink   (input valid, input ancestor, input status, output ready);
endinterface

FILE: hdl/lcab_ctrl.sv
// Sequencer for add and query items of the ancestor engine
module lcab_ctrl import lcab_pkg::*; #(
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

    ctrl_state_t   state_reg, state_next;
    logic [LW-1:0] k_reg, k_next;

    // State and level counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.level  = LVL_W'(k_reg);
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_query)
                begin
                    cmd.op     = OP_QDA;
                    state_next = S_Q_DB;
                end
                else if (stat.bad_add)
                begin
                    state_next = S_OUT_ADD;
                end
                else
                begin
                    cmd.op     = OP_ADD_RD;
                    state_next = S_ADD_DEP;
                end
            end
            S_ADD_DEP:
            begin
                cmd.op = OP_ADD_DEP;
                if (LEVELS == 1)
                begin
                    state_next = S_OUT_ADD;
                end
                else
                begin
                    k_next     = LW'(1);
                    state_next = S_ADD_LVL;
                end
            end
            S_ADD_LVL:
            begin
                cmd.op = OP_ADD_LVL;
                if (k_reg == LAST)
                begin
                    state_next = S_OUT_ADD;
                end
                else
                begin
                    k_next = LW'(k_reg + 1'b1);
                end
            end
            S_Q_DB:
            begin
                cmd.op     = OP_QDB;
                state_next = S_Q_DIFF;
            end
            S_Q_DIFF:
            begin
                cmd.op     = OP_QDIFF;
                k_next     = '0;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                cmd.op = OP_LIFT;
                if (k_reg == LAST)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    k_next = LW'(k_reg + 1'b1);
                end
            end
            S_CHECK:
            begin
                // Lifted node already equals the other one: it is the answer
                if (stat.same)
                begin
                    state_next = S_OUT_A;
                end
                else
                begin
                    k_next     = LAST;
                    state_next = S_JOINT;
                end
            end
            S_JOINT:
            begin
                cmd.op = OP_JOINT;
                if (k_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    k_next = LW'(k_reg - 1'b1);
                end
            end
            S_FINAL:
            begin
                cmd.op     = OP_FINRD;
                cmd.level  = '0;
                state_next = S_OUT_J;
            end
            S_OUT_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_ADD;
                    state_next = S_IDLE;
                end
            end
            S_OUT_A:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_A;
                    state_next = S_IDLE;
                end
            end
            S_OUT_J:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_J;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lcab_dpath.sv
// Depth store, jump table and node registers of the ancestor engine
module lcab_dpath import lcab_pkg::*; #(
    parameter int NODES  = DEF_NODES,
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              in_func,
    input  logic [NODE_W-1:0] in_node,
    input  logic [NODE_W-1:0] in_other,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NODE_W-1:0] out_ancestor,
    output logic              out_status
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Map a node number to the root when it lies outside the store
    function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] v);
        clamp_node = (32'(v) < 32'(NODES)) ? v : '0;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] v);
        logic [31:0] e;
        e       = 32'(v);
        to_addr = e[AW-1:0];
    endfunction

    // Stores
    logic [NODE_W-1:0] dmem [NODES];
    logic [NODE_W-1:0] jmem [NODES][LEVELS];

    // Item and working registers
    logic              func_reg;
    logic [NODE_W-1:0] node_reg, other_reg;
    logic [NODE_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [NODE_W-1:0] da_reg, diff_reg;
    logic              fwd_lift_reg, fwd_join_reg;
    logic              out_valid_reg;
    logic [NODE_W-1:0] ancestor_reg;
    logic              status_reg;

    // Read data and root flags
    logic [NODE_W-1:0] dq_raw, qa_raw, qb_raw;
    logic              dq_zero, qa_zero, qb_zero;
    logic [NODE_W-1:0] dq_eff, qa_eff, qb_eff, na, nb;
    logic [NODE_W-1:0] a_cur, b_cur;

    // Port selects
    logic              d_re, d_we, ja_re, jb_re, j_we;
    logic [AW-1:0]     d_raddr, ja_addr, jb_addr, w_addr;
    logic [LW-1:0]     lvl, ja_lvl;
    logic [NODE_W-1:0] j_wdata, diff_sh;
    logic              bad_add;

    // Root entries read as zero; they are never written
    assign dq_eff = dq_zero ? '0 : dq_raw;
    assign qa_eff = qa_zero ? '0 : qa_raw;
    assign qb_eff = qb_zero ? '0 : qb_raw;
    assign na     = clamp_node(qa_eff);
    assign nb     = clamp_node(qb_eff);

    // Take the jump read of the last cycle into the working nodes
    always_comb
    begin
        a_cur = a_reg;
        b_cur = b_reg;
        if (fwd_lift_reg)
        begin
            a_cur = na;
        end
        else if (fwd_join_reg && (na != nb))
        begin
            a_cur = na;
            b_cur = nb;
        end
    end

    assign lvl     = cmd.level[LW-1:0];
    assign w_addr  = to_addr(node_reg);
    assign diff_sh = diff_reg >> cmd.level;
    assign bad_add = (node_reg == '0) || (other_reg >= node_reg)
                   || (32'(node_reg) >= 32'(NODES));

    // Memory port controls
    always_comb
    begin
        d_re    = (cmd.op == OP_ADD_RD) || (cmd.op == OP_QDA) || (cmd.op == OP_QDB);
        d_raddr = (cmd.op == OP_QDA) ? to_addr(a_reg) : to_addr(b_reg);
        d_we    = (cmd.op == OP_ADD_DEP);
        ja_re   = (cmd.op == OP_ADD_RD) || (cmd.op == OP_ADD_LVL) || (cmd.op == OP_LIFT)
                || (cmd.op == OP_JOINT) || (cmd.op == OP_FINRD);
        ja_lvl  = (cmd.op == OP_ADD_RD) ? '0 : lvl;
        case (cmd.op)
            OP_ADD_RD:  ja_addr = to_addr(b_reg);
            OP_ADD_LVL: ja_addr = to_addr(na);
            default:    ja_addr = to_addr(a_cur);
        endcase
        jb_re   = (cmd.op == OP_JOINT);
        jb_addr = to_addr(b_cur);
        j_we    = (cmd.op == OP_ADD_RD) || (cmd.op == OP_ADD_LVL);
        j_wdata = (cmd.op == OP_ADD_RD) ? other_reg : qa_eff;
    end

    // Depth store
    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dmem[w_addr] <= NODE_W'(dq_eff + 1'b1);
        end
        if (d_re)
        begin
            dq_raw  <= dmem[d_raddr];
            dq_zero <= (d_raddr == '0);
        end
    end

    // Jump table: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (j_we)
        begin
            jmem[w_addr][ja_lvl] <= j_wdata;
        end
        if (ja_re)
        begin
            qa_raw  <= jmem[ja_addr][ja_lvl];
            qa_zero <= (ja_addr == '0);
        end
        if (jb_re)
        begin
            qb_raw  <= jmem[jb_addr][lvl];
            qb_zero <= (jb_addr == '0);
        end
    end

    // Working node updates
    always_comb
    begin
        a_next = a_cur;
        b_next = b_cur;
        case (cmd.op)
            OP_LOAD:
            begin
                a_next = clamp_node(in_node);
                b_next = clamp_node(in_other);
            end
            OP_QDIFF:
            begin
                if (da_reg < dq_eff)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            default:
            begin
                a_next = a_cur;
                b_next = b_cur;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.op == OP_LOAD)
        begin
            func_reg  <= in_func;
            node_reg  <= in_node;
            other_reg <= in_other;
        end
        if (cmd.op == OP_QDB)
        begin
            da_reg <= dq_eff;
        end
        if (cmd.op == OP_QDIFF)
        begin
            diff_reg <= (da_reg < dq_eff) ? NODE_W'(dq_eff - da_reg)
                                          : NODE_W'(da_reg - dq_eff);
        end
        case (cmd.op)
            OP_OUT_ADD:
            begin
                ancestor_reg <= '0;
                status_reg   <= bad_add;
            end
            OP_OUT_A:
            begin
                ancestor_reg <= a_reg;
                status_reg   <= 1'b0;
            end
            OP_OUT_J:
            begin
                ancestor_reg <= na;
                status_reg   <= 1'b0;
            end
            default:
            begin
                ancestor_reg <= ancestor_reg;
                status_reg   <= status_reg;
            end
        endcase
    end

    // Forward flags and result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_lift_reg  <= 1'b0;
            fwd_join_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_lift_reg <= (cmd.op == OP_LIFT) && diff_sh[0];
            fwd_join_reg <= (cmd.op == OP_JOINT);
            if ((cmd.op == OP_OUT_ADD) || (cmd.op == OP_OUT_A) || (cmd.op == OP_OUT_J))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.bad_add  = bad_add;
    assign stat.is_query = func_reg;
    assign stat.same     = (a_cur == b_cur);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_ancestor = ancestor_reg;
    assign out_status   = status_reg;

endmodule

FILE: hdl/lca_binary_lifting.sv
// Top level of the binary lifting lowest common ancestor engine
//
//  channel   dir   fields                      beat
//  in_ch     in    func, node, other           one add or query item
//  out_ch    out   ancestor, status            one result per item
//
// A query lifts the deeper node, then both nodes together; it skips the
// joint steps when the lifted node meets the other node. An add writes its
// jump entries. The jump table read loop takes one level per cycle, the
// next address from the registered read data of the last one.
// Reset clears control only; root entries read as zero, no clearing pass.
// A new item is taken while the last result beat waits; a stalled result
// holds the engine before its next result.
module lca_binary_lifting import lcab_pkg::*; #(
    parameter int NODES  = DEF_NODES,
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic         clk,
    input  logic         rst_n,
    lcab_in_if.sink      in_ch,
    lcab_out_if.source   out_ch
);

`include "assert_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lcab_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcab_dpath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_func      (in_ch.func),
        .in_node      (in_ch.node),
        .in_other     (in_ch.other),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_ancestor (out_ch.ancestor),
        .out_status   (out_ch.status)
    );

    // Engine turns busy after each accepted beat
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    // Item load happens only on an accepted beat
    `ASSERT_IMPL(a_load_on_accept, clk, rst_n, cmd.op == OP_LOAD, in_ch.valid && in_ch.ready)
    // A fresh result leaves the engine ready for the next item
    `ASSERT_IMPL(a_ready_after_result, clk, rst_n, $rose(out_ch.valid), in_ch.ready)

endmodule

FILE: tb/testbench.sv
// Testbench for the binary lifting lowest common ancestor engine
module testbench import lcab_pkg::*;;
    localparam int NODES        = DEF_NODES;
    localparam int LEVELS       = DEF_LEVELS;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 2 * LEVELS + 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum bit {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } item_func_t;

    typedef enum bit {
        STATUS_OK     = 1'b0,
        STATUS_REJECT = 1'b1
    } item_status_t;

    typedef struct packed {
        bit [NODE_W-1:0] ancestor;
        item_status_t    status;
    } lca_result_t;

    // Tree mirror plus the queue of results still owed by the engine
    class lca_scoreboard;
        bit [NODE_W-1:0] depth_of [DEF_NODES];
        bit [NODE_W-1:0] hop [DEF_NODES][DEF_LEVELS];
        lca_result_t     awaited[$];
        int adds_placed;
        int adds_rejected;
        int queries;
        int deepest;
        int beats_checked;
        int mismatches;

        // Lift the deeper node to the same depth, then both together from the top
        function bit [NODE_W-1:0] lowest_shared(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
            bit [NODE_W-1:0] swap;
            bit [NODE_W-1:0] diff;
            bit [NODE_W-1:0] up_a;
            bit [NODE_W-1:0] up_b;
            if (depth_of[a] < depth_of[b])
            begin
                swap = a;
                a    = b;
                b    = swap;
            end
            diff = depth_of[a] - depth_of[b];
            for (int k = 0; k < DEF_LEVELS; k++)
            begin
                if (diff[k])
                    a = hop[a][k];
            end
            if (a == b)
                return a;
            for (int k = DEF_LEVELS - 1; k >= 0; k--)
            begin
                up_a = hop[a][k];
                up_b = hop[b][k];
                if (up_a != up_b)
                begin
                    a = up_a;
                    b = up_b;
                end
            end
            return hop[a][0];
        endfunction

        // Apply an accepted input beat to the mirror and queue its result
        function void note_item(item_func_t f, bit [NODE_W-1:0] n, bit [NODE_W-1:0] o);
            lca_result_t res;
            res.ancestor = '0;
            res.status   = STATUS_OK;
            if (f == FUNC_ADD)
            begin
                if (n == 0 || o >= n)
                begin
                    res.status = STATUS_REJECT;
                    adds_rejected++;
                end
                else
                begin
                    depth_of[n] = depth_of[o] + 1'b1;
                    hop[n][0]   = o;
                    for (int k = 1; k < DEF_LEVELS; k++)
                        hop[n][k] = hop[hop[n][k-1]][k-1];
                    if (depth_of[n] > deepest)
                        deepest = depth_of[n];
                    adds_placed++;
                end
            end
            else
            begin
                res.ancestor = lowest_shared(n, o);
                queries++;
            end
            awaited = {awaited, res};
        endfunction

        // Compare a result beat with the oldest owed result
        function void check_result(logic [NODE_W-1:0] anc, logic st);
            lca_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: ancestor %0d status %0d", anc, st);
                return;
            end
            want = awaited.pop_front();
            beats_checked++;
            if (anc !== want.ancestor || st !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat %0d: expected ancestor %0d status %0d, ",
                              "got ancestor %0d status %0d"},
                             beats_checked, want.ancestor, want.status, anc, st);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lcab_in_if  in_ch();
    lcab_out_if out_ch();

    lca_binary_lifting #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lca_scoreboard sb = new();

    // Stimulus bookkeeping: which nodes hold written entries
    bit node_known [NODES];
    int known_list[$];
    int next_fresh;
    int chain_tip;
    int sent_count;
    int results_seen;
    int cycle_count;
    bit hold_results;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, sb.awaited.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one beat after a random gap, none in every fourth run of 40 beats, and hold it until taken
    task automatic send_item(item_func_t f, int n, int o);
        int gap;
        bit [NODE_W-1:0] n_bits;
        bit [NODE_W-1:0] o_bits;
        n_bits = NODE_W'(n);
        o_bits = NODE_W'(o);
        gap = ((sent_count / 40) % 4 == 3) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= f;
        in_ch.node  <= n_bits;
        in_ch.other <= o_bits;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_item(f, n_bits, o_bits);
        sent_count++;
    endtask

    // Send a well-formed add and remember the node as written
    task automatic add_node(int v, int p);
        send_item(FUNC_ADD, v, p);
        if (!node_known[v])
        begin
            node_known[v] = 1'b1;
            known_list = {known_list, v};
        end
    endtask

    // Pick a written node numbered below v, falling back to the root
    function automatic int known_below(int v);
        int cand;
        repeat (8)
        begin
            cand = known_list[$urandom_range(0, known_list.size() - 1)];
            if (cand < v)
                return cand;
        end
        return 0;
    endfunction

    function automatic int any_known();
        return known_list[$urandom_range(0, known_list.size() - 1)];
    endfunction

    // One random beat: mostly well-formed tree growth and queries
    task automatic random_item();
        int roll;
        int v;
        int p;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            if ($urandom_range(0, 4) != 0 && next_fresh <= NODES - 2)
            begin
                // grow a new node, mostly on the current chain to gain depth
                v = next_fresh;
                next_fresh += $urandom_range(1, 3);
                p = ($urandom_range(0, 9) < 8) ? chain_tip : known_below(v);
                chain_tip = v;
            end
            else
            begin
                // re-add an existing node under another parent
                v = known_list[$urandom_range(1, known_list.size() - 1)];
                p = known_below(v);
            end
            add_node(v, p);
        end
        else if (roll < 55)
        begin
            // malformed add: root as node, or parent not below node
            if ($urandom_range(0, 2) == 0)
                send_item(FUNC_ADD, 0, $urandom_range(0, NODES - 1));
            else
            begin
                v = $urandom_range(1, NODES - 1);
                send_item(FUNC_ADD, v, $urandom_range(v, NODES - 1));
            end
        end
        else
        begin
            v = any_known();
            p = ($urandom_range(0, 3) == 0) ? chain_tip : any_known();
            send_item(FUNC_QUERY, v, p);
        end
    endtask

    // Take result beats with random stalls and check each one
    initial
    begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = ((results_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, 9);
            if (gap > 0 || hold_results)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_results) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            sb.check_result(out_ch.ancestor, out_ch.status);
            results_seen++;
        end
    end

    // Hold off results for a long stretch so the engine backs up its input
    initial
    begin : result_hold
        hold_results = 1'b0;
        wait (results_seen >= 120);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Main sequence
    initial
    begin
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.func  <= FUNC_ADD;
        in_ch.node  <= '0;
        in_ch.other <= '0;
        sent_count   = 0;
        results_seen = 0;
        node_known[0] = 1'b1;
        known_list = {known_list, 0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // root against itself, then rejected adds
        send_item(FUNC_QUERY, 0, 0);
        send_item(FUNC_ADD, 0, 0);
        send_item(FUNC_ADD, 5, 5);
        send_item(FUNC_ADD, 3, NODES - 1);
        // small tree: 0-1-2-3 and 1-4
        add_node(1, 0);
        add_node(2, 1);
        add_node(3, 2);
        add_node(4, 1);
        send_item(FUNC_QUERY, 3, 4);
        send_item(FUNC_QUERY, 4, 3);
        send_item(FUNC_QUERY, 3, 1);
        send_item(FUNC_QUERY, 2, 2);
        // highest node number
        add_node(NODES - 1, 3);
        send_item(FUNC_QUERY, NODES - 1, 4);
        send_item(FUNC_QUERY, 0, NODES - 1);
        send_item(FUNC_ADD, NODES - 1, NODES - 1);
        // move node 2 under the root; node 3 keeps its old entries
        add_node(2, 0);
        send_item(FUNC_QUERY, 3, 4);
        send_item(FUNC_QUERY, 2, 4);
        send_item(FUNC_QUERY, NODES - 1, 2);
        send_item(FUNC_QUERY, 1, 0);

        next_fresh = 5;
        chain_tip  = 3;
        repeat (RANDOM_ITEMS) random_item();
        in_ch.valid <= 1'b0;

        // drain owed results, then watch for strays
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d adds placed, %0d adds rejected, %0d queries",
                 sent_count, sb.adds_placed, sb.adds_rejected, sb.queries);
        $display("deepest node at depth %0d; %0d results compared, %0d mismatched",
                 sb.deepest, sb.beats_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/lcab_pkg.sv
hdl/lcab_ifs.sv
hdl/lcab_ctrl.sv
hdl/lcab_dpath.sv
hdl/lca_binary_lifting.sv
tb/testbench.sv
